FILE: sv/ttcad_pkg.sv
// Shared codes, constants and helper functions of the teletext cell attribute decoder.
package ttcad_pkg;

  localparam int COLUMNS_DEF   = 40;
  localparam int PAGE_ROWS_DEF = 25;

  // height modes
  localparam logic [1:0] HM_SINGLE = 2'd0;
  localparam logic [1:0] HM_TOP    = 2'd1;
  localparam logic [1:0] HM_BOTTOM = 2'd2;

  // attribute codes
  localparam logic [7:0] C_BASE       = 8'h80;
  localparam logic [7:0] C_HEIGHT_OFF = 8'h8C;
  localparam logic [7:0] C_HEIGHT_ON  = 8'h8D;
  localparam logic [7:0] C_CONTIG     = 8'h99;
  localparam logic [7:0] C_SEPARATE   = 8'h9A;
  localparam logic [7:0] C_BG_BLACK   = 8'h9C;
  localparam logic [7:0] C_BG_NEW     = 8'h9D;
  localparam logic [7:0] C_HOLD_ON    = 8'h9E;
  localparam logic [7:0] C_HOLD_OFF   = 8'h9F;
  localparam logic [7:0] C_PRINT_LO   = 8'hA0;
  localparam logic [7:0] C_BLAST_LO   = 8'hC0;
  localparam logic [7:0] C_BLAST_HI   = 8'hDF;

  localparam logic [7:0] HELD_RESET = 8'h20;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [2:0] FG_RESET   = 3'd7;
  localparam logic [2:0] BG_RESET   = 3'd0;

  // lit sixels: code bits 0..4 then bit 6
  function automatic logic [5:0] sixel_bits(input logic [7:0] d);
    sixel_bits = {d[6], d[4:0]};
  endfunction

  function automatic logic code_is_bad(input logic [7:0] b);
    code_is_bad = (b == C_BASE) || (b inside {[8'h88:8'h8B]}) ||
                  (b inside {[8'h8E:8'h90]}) || (b == 8'h98) || (b == 8'h9B);
  endfunction

endpackage

FILE: sv/teletext_cell_attribute_decoder.sv
// Top level of the teletext serial attribute decoder: one page byte in, one cell word out.
// Each accepted input word has its result word in the output register the cycle after.
// Throughput: one word per cycle while out_stall is low; the attribute registers and the
//   two-port column height store close their loop; the output register parts both sides.
// Reset (rst_n low, synchronous): position (0,0), alphanumeric white on black, contiguous,
//   single height, hold off, held code space; the height store needs no clearing because
//   row 0 never reads it.
module teletext_cell_attribute_decoder #(
  parameter int COLUMNS   = ttcad_pkg::COLUMNS_DEF,
  parameter int PAGE_ROWS = ttcad_pkg::PAGE_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_code_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_column,
  output logic [4:0] out_row,
  output logic       out_is_sixel,
  output logic [6:0] out_char_code,
  output logic [5:0] out_sixel_mask,
  output logic       out_separated,
  output logic [2:0] out_fg_colour,
  output logic [2:0] out_bg_colour,
  output logic [1:0] out_height_mode,
  output logic       out_bad_code
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(PAGE_ROWS - 1);

  // position and serial attribute state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             alpha_r, alpha_nxt;
  logic             sep_r, sep_nxt;
  logic             dbl_r, dbl_nxt;
  logic             hold_r, hold_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [2:0]       fg_r, fg_nxt;
  logic [2:0]       bg_r, bg_nxt;

  // height store: one entry per column, holds the mode of the cell drawn above.
  // above_r is prefetched for the column that comes next.
  logic [1:0]       hgt_mem [COLUMNS];
  logic [1:0]       above_r;

  // output register
  logic             out_valid_r;
  logic [5:0]       column_r;
  logic [4:0]       row_o_r;
  logic             is_sixel_r;
  logic [6:0]       char_code_r;
  logic [5:0]       sixel_mask_r;
  logic             separated_r;
  logic [2:0]       fg_o_r;
  logic [2:0]       bg_o_r;
  logic [1:0]       height_r;
  logic             bad_r;

  logic             load_out;
  logic             accept;
  logic [7:0]       b;
  logic [1:0]       above;
  logic [1:0]       height;
  logic [7:0]       d;
  logic             sixel;

  // the output register takes a new word when empty or being drained
  assign load_out = !out_valid_r || !out_stall;
  assign in_stall = !load_out;
  assign accept   = in_valid && load_out;

  assign b = {1'b1, in_code_byte[6:0]};

  always_comb begin
    // start from the row-start values at column 0
    if (col_r == '0) begin
      sep_nxt   = 1'b0;
      alpha_nxt = 1'b1;
      fg_nxt    = ttcad_pkg::FG_RESET;
      bg_nxt    = ttcad_pkg::BG_RESET;
      dbl_nxt   = 1'b0;
      hold_nxt  = 1'b0;
    end else begin
      sep_nxt   = sep_r;
      alpha_nxt = alpha_r;
      fg_nxt    = fg_r;
      bg_nxt    = bg_r;
      dbl_nxt   = dbl_r;
      hold_nxt  = hold_r;
    end

    // graphics mode and colour codes
    if (b == ttcad_pkg::C_CONTIG) begin
      sep_nxt   = 1'b0;
      alpha_nxt = 1'b0;
    end else if (b == ttcad_pkg::C_SEPARATE) begin
      sep_nxt   = 1'b1;
      alpha_nxt = 1'b0;
    end
    if (b inside {[8'h91:8'h97]}) begin
      fg_nxt    = b[2:0];
      alpha_nxt = 1'b0;
    end

    // alphanumeric colour codes
    if (b inside {[8'h81:8'h87]}) begin
      fg_nxt    = b[2:0];
      alpha_nxt = 1'b1;
    end

    if (b == ttcad_pkg::C_HEIGHT_OFF) begin
      dbl_nxt = 1'b0;
    end else if (b == ttcad_pkg::C_HEIGHT_ON) begin
      dbl_nxt = 1'b1;
    end

    // top row sees single height above it
    above = (row_r == '0) ? ttcad_pkg::HM_SINGLE : above_r;
    if (dbl_nxt) begin
      height = (above == ttcad_pkg::HM_TOP) ? ttcad_pkg::HM_BOTTOM : ttcad_pkg::HM_TOP;
    end else begin
      height = ttcad_pkg::HM_SINGLE;
    end

    if (b == ttcad_pkg::C_HOLD_ON) begin
      hold_nxt = 1'b1;
    end else if (b == ttcad_pkg::C_HOLD_OFF) begin
      hold_nxt = 1'b0;
    end

    // background uses the colour after this cell's codes
    if (b == ttcad_pkg::C_BG_BLACK) begin
      bg_nxt = ttcad_pkg::BG_RESET;
    end else if (b == ttcad_pkg::C_BG_NEW) begin
      bg_nxt = fg_nxt;
    end

    // draw: held sixel on control codes under hold, glyph for text, else a mosaic from b
    if (b < ttcad_pkg::C_PRINT_LO && hold_nxt) begin
      d     = held_r;
      sixel = 1'b1;
    end else if (b < ttcad_pkg::C_PRINT_LO ||
                 (b >= ttcad_pkg::C_BLAST_LO && b <= ttcad_pkg::C_BLAST_HI) ||
                 alpha_nxt) begin
      d     = b;
      sixel = 1'b0;
    end else begin
      d     = b;
      sixel = 1'b1;
    end
    held_nxt = sixel ? d : held_r;

    // advance position, wrap at row and page end
    if (col_r == COL_LAST) begin
      col_nxt = '0;
      row_nxt = (row_r == ROW_LAST) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  // height store: write this column, prefetch the next one
  always_ff @(posedge clk) begin
    if (accept) begin
      hgt_mem[col_r] <= height;
      if (col_nxt == col_r) begin
        above_r <= height;
      end else begin
        above_r <= hgt_mem[col_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      alpha_r <= 1'b1;
      sep_r   <= 1'b0;
      dbl_r   <= 1'b0;
      hold_r  <= 1'b0;
      held_r  <= ttcad_pkg::HELD_RESET;
      fg_r    <= ttcad_pkg::FG_RESET;
      bg_r    <= ttcad_pkg::BG_RESET;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      alpha_r <= alpha_nxt;
      sep_r   <= sep_nxt;
      dbl_r   <= dbl_nxt;
      hold_r  <= hold_nxt;
      held_r  <= held_nxt;
      fg_r    <= fg_nxt;
      bg_r    <= bg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= accept;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      column_r     <= 6'(col_r);
      row_o_r      <= 5'(row_r);
      is_sixel_r   <= sixel;
      char_code_r  <= (d >= ttcad_pkg::C_PRINT_LO) ? d[6:0] : ttcad_pkg::CHAR_SPACE;
      sixel_mask_r <= sixel ? ttcad_pkg::sixel_bits(d) : 6'd0;
      separated_r  <= sep_nxt;
      fg_o_r       <= fg_nxt;
      bg_o_r       <= bg_nxt;
      height_r     <= height;
      bad_r        <= ttcad_pkg::code_is_bad(b);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column      = column_r;
  assign out_row         = row_o_r;
  assign out_is_sixel    = is_sixel_r;
  assign out_char_code   = char_code_r;
  assign out_sixel_mask  = sixel_mask_r;
  assign out_separated   = separated_r;
  assign out_fg_colour   = fg_o_r;
  assign out_bg_colour   = bg_o_r;
  assign out_height_mode = height_r;
  assign out_bad_code    = bad_r;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the teletext cell attribute decoder: directed table then random pages.
`timescale 1ns / 1ps

module tb;

  // One decoded cell, field for field as the result ports present it.
  typedef struct packed {
    logic [5:0] column;
    logic [4:0] row;
    logic       is_sixel;
    logic [6:0] char_code;
    logic [5:0] sixel_mask;
    logic       separated;
    logic [2:0] fg_colour;
    logic [2:0] bg_colour;
    logic [1:0] height_mode;
    logic       bad_code;
  } cell_t;

  // One stimulus word; typed marks a row whose expected cell is written out by hand.
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    cell_t      exp_cell;
  } cell_step_t;

  // Attribute codes the package leaves unnamed.
  localparam logic [7:0] C_ALPHA_RED = 8'h81;
  localparam logic [7:0] C_ALPHA_WHITE = 8'h87;
  localparam logic [7:0] C_GFX_RED = 8'h91;
  localparam logic [7:0] C_GFX_WHITE = 8'h97;
  localparam logic [7:0] C_BAD_A_LO = 8'h88;
  localparam logic [7:0] C_BAD_A_HI = 8'h8B;
  localparam logic [7:0] C_BAD_B_LO = 8'h8E;
  localparam logic [7:0] C_BAD_B_HI = 8'h90;
  localparam logic [7:0] C_BAD_C = 8'h98;
  localparam logic [7:0] C_BAD_D = 8'h9B;
  // Clear bit 7: the block must set it again on its own.
  localparam logic [7:0] LOW7 = 8'h7F;

  localparam int RANDOM_PER_PHASE = 330;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;

  // Directed opening, all on row 0 right after reset. Hand-typed cells are the ones that
  // follow at a glance: the reset state, full-scale bytes and invalid codes.
  localparam int DIRECTED_ROWS = 25;
  localparam cell_step_t DIRECTED [DIRECTED_ROWS] = '{
    '{ttcad_pkg::C_BASE & LOW7, 1'b1,
      '{6'd0, 5'd0, 1'b0, ttcad_pkg::CHAR_SPACE, 6'd0, 1'b0, ttcad_pkg::FG_RESET,
        ttcad_pkg::BG_RESET, ttcad_pkg::HM_SINGLE, 1'b1}},
    '{8'hFF, 1'b1,
      '{6'd1, 5'd0, 1'b0, 7'h7F, 6'd0, 1'b0, ttcad_pkg::FG_RESET,
        ttcad_pkg::BG_RESET, ttcad_pkg::HM_SINGLE, 1'b0}},
    '{C_GFX_RED & LOW7, 1'b0, '0},
    '{8'hFF, 1'b1,
      '{6'd3, 5'd0, 1'b1, 7'h7F, 6'h3F, 1'b0, 3'd1,
        ttcad_pkg::BG_RESET, ttcad_pkg::HM_SINGLE, 1'b0}},
    '{8'hC5, 1'b0, '0},               // blast-through capital in graphics mode
    '{ttcad_pkg::C_SEPARATE, 1'b0, '0},
    '{ttcad_pkg::C_PRINT_LO, 1'b0, '0},          // empty sixel
    '{8'hB5, 1'b0, '0},
    '{ttcad_pkg::C_HOLD_ON & LOW7, 1'b0, '0},    // held sixel repeats the last one
    '{C_BAD_A_LO, 1'b0, '0},          // invalid code under hold
    '{ttcad_pkg::C_HOLD_OFF, 1'b0, '0},
    '{ttcad_pkg::C_CONTIG & LOW7, 1'b0, '0},
    '{ttcad_pkg::C_HEIGHT_ON & LOW7, 1'b0, '0},  // top row: always a top half
    '{ttcad_pkg::C_BG_NEW, 1'b0, '0},
    '{C_ALPHA_WHITE & LOW7, 1'b0, '0},
    '{ttcad_pkg::C_BG_BLACK & LOW7, 1'b0, '0},
    '{ttcad_pkg::C_HEIGHT_OFF, 1'b0, '0},
    '{C_BAD_A_HI & LOW7, 1'b0, '0},
    '{C_BAD_B_LO, 1'b0, '0},
    '{C_BAD_B_HI & LOW7, 1'b0, '0},
    '{C_BAD_C, 1'b1,
      '{6'd20, 5'd0, 1'b0, ttcad_pkg::CHAR_SPACE, 6'd0, 1'b0, ttcad_pkg::FG_RESET,
        ttcad_pkg::BG_RESET, ttcad_pkg::HM_SINGLE, 1'b1}},
    '{C_BAD_D & LOW7, 1'b0, '0},
    '{C_GFX_WHITE, 1'b0, '0},
    '{LOW7, 1'b0, '0},                // full sixel from a byte with bit 7 clear
    '{C_ALPHA_RED, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_code_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_column;
  logic [4:0] out_row;
  logic       out_is_sixel;
  logic [6:0] out_char_code;
  logic [5:0] out_sixel_mask;
  logic       out_separated;
  logic [2:0] out_fg_colour;
  logic [2:0] out_bg_colour;
  logic [1:0] out_height_mode;
  logic       out_bad_code;

  teletext_cell_attribute_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_code_byte(in_code_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_column(out_column),
    .out_row(out_row),
    .out_is_sixel(out_is_sixel),
    .out_char_code(out_char_code),
    .out_sixel_mask(out_sixel_mask),
    .out_separated(out_separated),
    .out_fg_colour(out_fg_colour),
    .out_bg_colour(out_bg_colour),
    .out_height_mode(out_height_mode),
    .out_bad_code(out_bad_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted decoder state, mirrored from reset.
  int         cur_col = 0;
  int         cur_row = 0;
  logic       alpha_on = 1'b1;
  logic       sep_on = 1'b0;
  logic       dbl_on = 1'b0;
  logic       hold_active = 1'b0;
  logic [7:0] last_sixel_code = ttcad_pkg::HELD_RESET;
  logic [2:0] fg_now = ttcad_pkg::FG_RESET;
  logic [2:0] bg_now = ttcad_pkg::BG_RESET;
  logic [1:0] height_above [ttcad_pkg::COLUMNS_DEF];

  cell_t      pending_cells [$];   // predicted cells waiting for their result word
  cell_step_t typed_cells [$];     // per driven word: hand-typed cell, if any
  int         fail_count = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         send_gap_pct = 0;
  int         stall_pct = 0;
  int         cells_driven = 0;
  int         idle_cycles = 0;

  initial begin
    foreach (height_above[i]) height_above[i] = ttcad_pkg::HM_SINGLE;
  end

  // Decode one page byte against the predicted attribute state and advance the position.
  function automatic cell_t decode_cell(input logic [7:0] raw);
    logic [7:0] b;
    logic [7:0] shown;
    logic [1:0] above;
    cell_t      c;
    b = raw | ttcad_pkg::C_BASE;
    c = '0;
    // Every row opens in alphanumeric white on black, contiguous, single height, no hold.
    if (cur_col == 0) begin
      sep_on = 1'b0;
      alpha_on = 1'b1;
      fg_now = ttcad_pkg::FG_RESET;
      bg_now = ttcad_pkg::BG_RESET;
      dbl_on = 1'b0;
      hold_active = 1'b0;
    end
    if (b == ttcad_pkg::C_CONTIG) begin
      sep_on = 1'b0;
      alpha_on = 1'b0;
    end else if (b == ttcad_pkg::C_SEPARATE) begin
      sep_on = 1'b1;
      alpha_on = 1'b0;
    end
    if (b >= C_GFX_RED && b <= C_GFX_WHITE) begin
      fg_now = b[2:0];
      alpha_on = 1'b0;
    end
    if (b >= C_ALPHA_RED && b <= C_ALPHA_WHITE) begin
      fg_now = b[2:0];
      alpha_on = 1'b1;
    end
    if (b == ttcad_pkg::C_HEIGHT_OFF) dbl_on = 1'b0;
    else if (b == ttcad_pkg::C_HEIGHT_ON) dbl_on = 1'b1;
    // The top row has nothing above it, whatever the store still holds from the last page.
    above = (cur_row == 0) ? ttcad_pkg::HM_SINGLE : height_above[cur_col];
    if (dbl_on) begin
      c.height_mode = (above == ttcad_pkg::HM_TOP) ? ttcad_pkg::HM_BOTTOM : ttcad_pkg::HM_TOP;
    end else begin
      c.height_mode = ttcad_pkg::HM_SINGLE;
    end
    height_above[cur_col] = c.height_mode;
    if (b == ttcad_pkg::C_HOLD_ON) hold_active = 1'b1;
    else if (b == ttcad_pkg::C_HOLD_OFF) hold_active = 1'b0;
    if (b == ttcad_pkg::C_BG_BLACK) bg_now = ttcad_pkg::BG_RESET;
    else if (b == ttcad_pkg::C_BG_NEW) bg_now = fg_now;
    // Control cells under hold repeat the last sixel; otherwise glyph unless a graphics byte.
    if (b < ttcad_pkg::C_PRINT_LO && hold_active) begin
      shown = last_sixel_code;
      c.is_sixel = 1'b1;
    end else if (b < ttcad_pkg::C_PRINT_LO ||
                 (b >= ttcad_pkg::C_BLAST_LO && b <= ttcad_pkg::C_BLAST_HI) || alpha_on) begin
      shown = b;
      c.is_sixel = 1'b0;
    end else begin
      shown = b;
      c.is_sixel = 1'b1;
    end
    if (c.is_sixel) last_sixel_code = shown;
    c.column = 6'(cur_col);
    c.row = 5'(cur_row);
    c.char_code = (shown >= ttcad_pkg::C_PRINT_LO) ? shown[6:0] : ttcad_pkg::CHAR_SPACE;
    c.sixel_mask = c.is_sixel ? {shown[6], shown[4:0]} : 6'd0;
    c.separated = sep_on;
    c.fg_colour = fg_now;
    c.bg_colour = bg_now;
    c.bad_code = (b == ttcad_pkg::C_BASE) || (b >= C_BAD_A_LO && b <= C_BAD_A_HI) ||
                 (b >= C_BAD_B_LO && b <= C_BAD_B_HI) || b == C_BAD_C || b == C_BAD_D;
    // Advance in row order and wrap at the page end.
    cur_col++;
    if (cur_col >= ttcad_pkg::COLUMNS_DEF) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= ttcad_pkg::PAGE_ROWS_DEF) cur_row = 0;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Pick a random page byte. Half the rows open with double height and most with a graphics
  // colour or separated mode so that sixels, hold and bottom halves come up often; the rest
  // is controls, printable bytes and raw noise, each with bit 7 either way.
  function automatic logic [7:0] pick_byte(input int col);
    logic [7:0] pick;
    int         r;
    r = $urandom_range(0, 99);
    if (col == 0 && r < 50) begin
      pick = ttcad_pkg::C_HEIGHT_ON;
    end else if (col == 1 && r < 60) begin
      pick = (r < 10) ? ttcad_pkg::C_SEPARATE : 8'($urandom_range(C_GFX_RED, C_GFX_WHITE));
    end else if (r < 25) begin
      pick = {1'b1, 2'b00, 5'($urandom_range(0, 31))};
    end else if (r < 92) begin
      pick = 8'($urandom_range(ttcad_pkg::C_PRINT_LO, 8'hFF));
    end else begin
      pick = 8'($urandom);
    end
    pick[7] = 1'($urandom_range(0, 1));
    return pick;
  endfunction

  // Drive one word and hold it until the block takes it. Valid stays high on return.
  task automatic send_word(input logic [7:0] code, input logic typed, input cell_t exp_cell);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_cells.push_back('{code, typed, exp_cell});
    in_valid <= 1'b1;
    in_code_byte <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    cells_driven++;
  endtask

  // Drop valid and hold off until every word sent has come back and been checked.
  task automatic drain;
    in_valid <= 1'b0;
    while (words_checked < words_sent) @(posedge clk);
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check result words first: a word leaving this edge can't belong to one entering now.
  always @(posedge clk) begin
    cell_t      got;
    cell_t      want;
    cell_step_t step;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_column, out_row, out_is_sixel, out_char_code, out_sixel_mask,
                out_separated, out_fg_colour, out_bg_colour, out_height_mode, out_bad_code};
        if (pending_cells.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          want = pending_cells.pop_front();
          check_field("column", 8'(want.column), 8'(got.column));
          check_field("row", 8'(want.row), 8'(got.row));
          check_field("is_sixel", 8'(want.is_sixel), 8'(got.is_sixel));
          check_field("char_code", 8'(want.char_code), 8'(got.char_code));
          check_field("sixel_mask", 8'(want.sixel_mask), 8'(got.sixel_mask));
          check_field("separated", 8'(want.separated), 8'(got.separated));
          check_field("fg_colour", 8'(want.fg_colour), 8'(got.fg_colour));
          check_field("bg_colour", 8'(want.bg_colour), 8'(got.bg_colour));
          check_field("height_mode", 8'(want.height_mode), 8'(got.height_mode));
          check_field("bad_code", 8'(want.bad_code), 8'(got.bad_code));
        end
        words_checked++;
      end
      if (in_valid && !in_stall) begin
        want = decode_cell(in_code_byte);
        if (typed_cells.size() != 0) begin
          step = typed_cells.pop_front();
          if (step.typed) want = step.exp_cell;
        end
        pending_cells.push_back(want);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("teletext_cell_attribute_decoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 0: sender mostly busy, receiver stalling hard.
    send_gap_pct = 9;
    stall_pct = 72;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].exp_cell);
    end
    // Hold off until the pipe is empty, then carry on from the same position.
    drain();
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_word(pick_byte(cells_driven % ttcad_pkg::COLUMNS_DEF), 1'b0, '0);
    end

    // Phase 1: the other way round.
    send_gap_pct = 72;
    stall_pct = 9;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_word(pick_byte(cells_driven % ttcad_pkg::COLUMNS_DEF), 1'b0, '0);
    end

    // Phase 2: full rate both ways; runs past the page end and wraps to row 0.
    send_gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_word(pick_byte(cells_driven % ttcad_pkg::COLUMNS_DEF), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cells.size() == 0) begin
      $display("teletext_cell_attribute_decoder test passed");
    end else begin
      $display("teletext_cell_attribute_decoder test failed");
    end
    $finish;
  end

endmodule
